FILE: rtl/isf_pkg.sv
// Shared types and constants for the 3x3 sharpen/blur image filter.
// No dependencies; imported by every isf_* module.
package isf_pkg;

    localparam int PIX_W  = 32;  // packed RGBA: red 7..0, green 15..8, blue 23..16, alpha 31..24
    localparam int CH_W   = 8;
    localparam int TAPS   = 9;
    localparam int CENTER = 4;
    localparam int ROWS   = 3;

    localparam int CFG_W_W   = 11;
    localparam int CFG_H_W   = 13;
    localparam int IMG_W_RST = 640;
    localparam int IMG_H_RST = 480;

    // config register indexes (byte address bits 3..2)
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    localparam logic MODE_SHARPEN = 1'b0;
    localparam logic MODE_BLUR    = 1'b1;

    // sharpen sum spans -1020..1275, box sum 0..2295
    localparam int SHARP_W = 12;
    localparam int SUM_W   = 12;

    // floor(sum/9) == (sum*7282) >> 16 for every sum below 2296
    localparam int            RECIP_W   = 13;
    localparam logic [12:0]   BOX_RECIP = 13'd7282;
    localparam int            BOX_SHIFT = 16;

    typedef struct packed {
        logic border;
        logic mode;
    } chan_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: rtl/isf_cell.sv
// One window cell: holds a pixel and takes its right neighbor's pixel on shift.
// Depends on isf_pkg.
module isf_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic [isf_pkg::PIX_W-1:0] d,
    output logic [isf_pkg::PIX_W-1:0] q
);
    import isf_pkg::*;

    logic [PIX_W-1:0] pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= '0;
        end
        else if (en)
        begin
            pix_reg <= d;
        end
    end

    assign q = pix_reg;

endmodule

FILE: rtl/isf_line_mem.sv
// Line store: single-port-write, single-port-read RAM with registered read data.
// Depends on isf_pkg.
module isf_line_mem #(
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [isf_pkg::PIX_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [isf_pkg::PIX_W-1:0] rd_data
);
    import isf_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/isf_chan.sv
// Per-channel kernel: registered sharpen and box sums, then clamp / divide-by-9.
// Border pixels pass through unfiltered. Depends on isf_pkg.
module isf_chan (
    input  logic                                      clk,
    input  logic                                      en,
    input  logic [isf_pkg::TAPS-1:0][isf_pkg::CH_W-1:0] taps,
    input  isf_pkg::chan_ctrl_t                       ctrl,
    output logic [isf_pkg::CH_W-1:0]                  result
);
    import isf_pkg::*;

    logic [SHARP_W-1:0]        pos_sum;
    logic [SHARP_W-1:0]        neg_sum;
    logic [SUM_W-1:0]          box_sum;
    logic signed [SHARP_W-1:0] sharp_reg;
    logic [SUM_W-1:0]          box_reg;
    logic [CH_W-1:0]           raw_reg;
    chan_ctrl_t                ctrl_reg;
    logic [SUM_W+RECIP_W-1:0]  box_prod;
    logic [CH_W-1:0]           sharp_clamp;

    always_comb
    begin
        pos_sum = (SHARP_W'(taps[CENTER]) << 2) + SHARP_W'(taps[CENTER]);
        neg_sum = SHARP_W'(taps[1]) + SHARP_W'(taps[3]) + SHARP_W'(taps[5])
                + SHARP_W'(taps[7]);
        box_sum = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            box_sum = box_sum + SUM_W'(taps[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sharp_reg <= signed'(pos_sum - neg_sum);
            box_reg   <= box_sum;
            raw_reg   <= taps[CENTER];
            ctrl_reg  <= ctrl;
        end
    end

    assign box_prod = (SUM_W+RECIP_W)'(box_reg) * (SUM_W+RECIP_W)'(BOX_RECIP);

    always_comb
    begin
        if (sharp_reg < 0)
        begin
            sharp_clamp = '0;
        end
        else if (sharp_reg > SHARP_W'(255))
        begin
            sharp_clamp = '1;
        end
        else
        begin
            sharp_clamp = sharp_reg[CH_W-1:0];
        end

        if (ctrl_reg.border)
        begin
            result = raw_reg;
        end
        else if (ctrl_reg.mode == MODE_BLUR)
        begin
            result = box_prod[BOX_SHIFT +: CH_W];
        end
        else
        begin
            result = sharp_clamp;
        end
    end

endmodule

FILE: rtl/isf_pos_div.sv
// Restoring divider, one quotient bit per cycle; splits the output position
// into row and column after a size change. Depends on isf_pkg.
module isf_pos_div #(
    parameter int N_W = 22,
    parameter int D_W = 11
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [N_W-1:0]     dividend,
    input  logic [D_W-1:0]     divisor,
    output isf_pkg::div_stat_t stat,
    output logic [N_W-1:0]     quot,
    output logic [D_W-1:0]     rem
);
    import isf_pkg::*;

    localparam int C_W = $clog2(N_W + 1);

    typedef enum logic [2:0] {
        DV_IDLE = 3'b001,
        DV_RUN  = 3'b010,
        DV_DONE = 3'b100
    } dv_state_t;

    dv_state_t      state_reg;
    logic [C_W-1:0] cnt_reg;
    logic [N_W-1:0] quo_reg;
    logic [D_W-1:0] rem_reg;
    logic [D_W:0]   trial;
    logic           ge;
    logic [D_W-1:0] rem_next;
    logic [N_W-1:0] quo_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[N_W-1]};
        ge       = (trial >= {1'b0, divisor});
        rem_next = ge ? D_W'(trial - {1'b0, divisor}) : trial[D_W-1:0];
        quo_next = {quo_reg[N_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end
        else if (start)
        begin
            state_reg <= DV_RUN;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                DV_RUN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == C_W'(N_W - 1))
                    begin
                        state_reg <= DV_DONE;
                    end
                end
                DV_DONE:
                begin
                    state_reg <= DV_IDLE;
                end
                default:
                begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (state_reg == DV_RUN)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = (state_reg != DV_IDLE);
    assign stat.done = (state_reg == DV_DONE);
    assign quot      = quo_reg;
    assign rem       = rem_reg;

endmodule

FILE: rtl/image_3x3_sharpen_blur_filter.sv
// Streaming 3x3 sharpen / box-blur filter for RGBA frames in raster order.
// A result leaves through the line store read, window shift, kernel sums and output
// register after the request that releases it. Throughput: one request per cycle while
// the output is not stalled. After a width or height write the input also stalls while
// the row/column divider runs. Reset clears counters and window; line stores hold
// nothing valid until written; registers come up 640 x 480, sharpen.
module image_3x3_sharpen_blur_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [7:0]  alpha_in,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [7:0]  alpha_out,
    output logic        frame_last,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import isf_pkg::*;

    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int A_W   = $clog2(MAX_WIDTH);
    localparam int P_W   = $clog2(MAX_WIDTH + 2);
    localparam int H_W   = $clog2(MAX_HEIGHT + 1);
    localparam int Y_W   = $clog2(MAX_HEIGHT);
    localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int W_RST = (IMG_W_RST > MAX_WIDTH) ? MAX_WIDTH : IMG_W_RST;
    localparam int H_RST = (IMG_H_RST > MAX_HEIGHT) ? MAX_HEIGHT : IMG_H_RST;

    // ---------------- configuration ----------------
    logic [CFG_W_W-1:0] w_raw_reg;
    logic [CFG_H_W-1:0] h_raw_reg;
    logic               mode_reg;
    logic [W_W-1:0]     w_eff_reg;
    logic [H_W-1:0]     h_eff_reg;
    logic [W_W-1:0]     w_wr_eff;
    logic [H_W-1:0]     h_wr_eff;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;
    logic               div_start;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        if (pwdata[CFG_W_W-1:0] == '0)
        begin
            w_wr_eff = W_W'(1);
        end
        else if (32'(pwdata[CFG_W_W-1:0]) > 32'(MAX_WIDTH))
        begin
            w_wr_eff = W_W'(MAX_WIDTH);
        end
        else
        begin
            w_wr_eff = W_W'(pwdata[CFG_W_W-1:0]);
        end

        if (pwdata[CFG_H_W-1:0] == '0)
        begin
            h_wr_eff = H_W'(1);
        end
        else if (32'(pwdata[CFG_H_W-1:0]) > 32'(MAX_HEIGHT))
        begin
            h_wr_eff = H_W'(MAX_HEIGHT);
        end
        else
        begin
            h_wr_eff = H_W'(pwdata[CFG_H_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_raw_reg <= CFG_W_W'(IMG_W_RST);
            h_raw_reg <= CFG_H_W'(IMG_H_RST);
            mode_reg  <= MODE_SHARPEN;
            w_eff_reg <= W_W'(W_RST);
            h_eff_reg <= H_W'(H_RST);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_WIDTH:
                begin
                    w_raw_reg <= pwdata[CFG_W_W-1:0];
                    w_eff_reg <= w_wr_eff;
                end
                REG_HEIGHT:
                begin
                    h_raw_reg <= pwdata[CFG_H_W-1:0];
                    h_eff_reg <= h_wr_eff;
                end
                REG_MODE:
                begin
                    mode_reg <= pwdata[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_WIDTH:  prdata = 32'(w_raw_reg);
            REG_HEIGHT: prdata = 32'(h_raw_reg);
            REG_MODE:   prdata = 32'(mode_reg);
            default:    prdata = '0;
        endcase
    end

    assign div_start = cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT);

    // ---------------- position divider ----------------
    div_stat_t        dv_stat;
    logic [POS_W-1:0] dv_quot;
    logic [W_W-1:0]   dv_rem;
    logic [POS_W-1:0] pos_reg;

    isf_pos_div #(
        .N_W (POS_W),
        .D_W (W_W)
    ) u_pos_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pos_reg),
        .divisor  (w_eff_reg),
        .stat     (dv_stat),
        .quot     (dv_quot),
        .rem      (dv_rem)
    );

    // ---------------- request stage ----------------
    logic           adv;
    logic           accept;
    logic           is_pix;
    logic           tok;
    logic           emit0;
    logic           border0;
    logic           last0;
    logic [A_W-1:0] col_reg;
    logic [P_W-1:0] pend_reg;
    logic [A_W-1:0] x_reg;
    logic [Y_W-1:0] y_reg;
    logic [P_W-1:0] w_plus1;
    logic [W_W-1:0] w_m1;
    logic [H_W-1:0] h_m1;
    logic           pend_full;
    logic           pend_zero;
    logic           col_last;
    logic           x_last;
    logic           y_last;
    logic [W_W:0]   drain_sum;
    logic [W_W:0]   drain_col;
    logic [A_W-1:0] rd_addr;

    // stage 1
    logic             s1_valid_reg;
    logic             s1_is_pix_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [A_W-1:0]   s1_addr_reg;
    logic             s1_emit_reg;
    logic             s1_border_reg;
    logic             s1_last_reg;
    logic             s1_fwd_reg;
    logic [PIX_W-1:0] fwd_top_reg;
    logic [PIX_W-1:0] fwd_mid_reg;
    logic             fwd_hit;
    logic             mem_wr;
    logic [PIX_W-1:0] top_rd;
    logic [PIX_W-1:0] mid_rd;
    logic [PIX_W-1:0] top_val;
    logic [PIX_W-1:0] mid_val;

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv || dv_stat.busy;
    assign accept   = in_valid && !in_stall;
    assign is_pix   = (func == FUNC_PIXEL);

    always_comb
    begin
        w_plus1   = P_W'(w_eff_reg) + P_W'(1);
        w_m1      = w_eff_reg - W_W'(1);
        h_m1      = h_eff_reg - H_W'(1);
        pend_full = (pend_reg == w_plus1);
        pend_zero = (pend_reg == '0);
        col_last  = (W_W'(col_reg) == w_m1);
        x_last    = (W_W'(x_reg) == w_m1);
        y_last    = (H_W'(y_reg) == h_m1);
        border0   = (y_reg == '0) || y_last || (x_reg == '0) || x_last;
        last0     = x_last && y_last;
        tok       = accept && (is_pix || !pend_zero);
        emit0     = is_pix ? pend_full : 1'b1;

        // drain reads the oldest column still waiting to be output
        drain_sum = (W_W+1)'(col_reg) + (W_W+1)'(w_plus1 - pend_reg);
        drain_col = (drain_sum >= (W_W+1)'(w_eff_reg))
                  ? drain_sum - (W_W+1)'(w_eff_reg) : drain_sum;
        rd_addr   = is_pix ? col_reg : drain_col[A_W-1:0];
        fwd_hit   = s1_valid_reg && s1_is_pix_reg && (s1_addr_reg == rd_addr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            pend_reg <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            pos_reg  <= '0;
        end
        else if (dv_stat.done)
        begin
            // re-fit counters to the new frame size
            if (dv_quot >= POS_W'(h_eff_reg))
            begin
                x_reg   <= '0;
                y_reg   <= '0;
                pos_reg <= '0;
            end
            else
            begin
                x_reg <= dv_rem[A_W-1:0];
                y_reg <= dv_quot[Y_W-1:0];
            end
            if (W_W'(col_reg) >= w_eff_reg)
            begin
                col_reg <= '0;
            end
            if (pend_reg > w_plus1)
            begin
                pend_reg <= w_plus1;
            end
        end
        else if (tok)
        begin
            if (is_pix)
            begin
                col_reg <= col_last ? '0 : col_reg + 1'b1;
                if (!pend_full)
                begin
                    pend_reg <= pend_reg + 1'b1;
                end
            end
            else
            begin
                pend_reg <= pend_reg - 1'b1;
            end
            if (emit0)
            begin
                if (x_last)
                begin
                    x_reg <= '0;
                    y_reg <= y_last ? '0 : y_reg + 1'b1;
                end
                else
                begin
                    x_reg <= x_reg + 1'b1;
                end
                pos_reg <= last0 ? '0 : pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= tok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_is_pix_reg <= is_pix;
            s1_pix_reg    <= is_pix ? {alpha_in, blue_in, green_in, red_in} : '0;
            s1_addr_reg   <= rd_addr;
            s1_emit_reg   <= emit0;
            s1_border_reg <= border0;
            s1_last_reg   <= last0;
            s1_fwd_reg    <= fwd_hit;
        end
        if (mem_wr)
        begin
            fwd_top_reg <= mid_val;
            fwd_mid_reg <= s1_pix_reg;
        end
    end

    // ---------------- line stores ----------------
    assign mem_wr  = adv && s1_valid_reg && s1_is_pix_reg;
    // same column written on the edge the read was taken: use the written data
    assign top_val = s1_fwd_reg ? fwd_top_reg : top_rd;
    assign mid_val = s1_fwd_reg ? fwd_mid_reg : mid_rd;

    isf_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (s1_addr_reg),
        .wr_data (mid_val),
        .rd_en   (adv),
        .rd_addr (rd_addr),
        .rd_data (top_rd)
    );

    isf_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (adv),
        .rd_addr (rd_addr),
        .rd_data (mid_rd)
    );

    // ---------------- window cells ----------------
    logic [PIX_W-1:0] win    [TAPS];
    logic [PIX_W-1:0] col_in [ROWS];
    logic             win_en;

    assign win_en    = adv && s1_valid_reg;
    assign col_in[0] = top_val;
    assign col_in[1] = mid_val;
    assign col_in[2] = s1_pix_reg;

    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        for (genvar c = 0; c < ROWS; c++)
        begin : g_col
            logic [PIX_W-1:0] cell_d;
            if (c == ROWS - 1)
            begin : g_edge
                assign cell_d = col_in[r];
            end
            else
            begin : g_inner
                assign cell_d = win[r*ROWS + c + 1];
            end
            isf_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (win_en),
                .d     (cell_d),
                .q     (win[r*ROWS + c])
            );
        end
    end

    // ---------------- stage 2 / kernel ----------------
    logic            s2_emit_reg;
    logic            s2_border_reg;
    logic            s2_last_reg;
    logic            s3_emit_reg;
    logic            s3_last_reg;
    logic [CH_W-1:0] s3_alpha_reg;
    chan_ctrl_t      ch_ctrl;
    logic [CH_W-1:0] ch_res [ROWS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_emit_reg <= 1'b0;
            s3_emit_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_emit_reg <= s1_valid_reg && s1_emit_reg;
            s3_emit_reg <= s2_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_border_reg <= s1_border_reg;
            s2_last_reg   <= s1_last_reg;
            s3_last_reg   <= s2_last_reg;
            s3_alpha_reg  <= win[CENTER][3*CH_W +: CH_W];
        end
    end

    assign ch_ctrl.border = s2_border_reg;
    assign ch_ctrl.mode   = mode_reg;

    for (genvar k = 0; k < ROWS; k++)
    begin : g_chan
        logic [TAPS-1:0][CH_W-1:0] taps;
        for (genvar i = 0; i < TAPS; i++)
        begin : g_tap
            assign taps[i] = win[i][k*CH_W +: CH_W];
        end
        isf_chan u_chan (
            .clk    (clk),
            .en     (adv),
            .taps   (taps),
            .ctrl   (ch_ctrl),
            .result (ch_res[k])
        );
    end

    // ---------------- output register ----------------
    logic            out_valid_reg;
    logic [CH_W-1:0] red_reg;
    logic [CH_W-1:0] green_reg;
    logic [CH_W-1:0] blue_reg;
    logic [CH_W-1:0] alpha_reg;
    logic            last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s3_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg   <= ch_res[0];
            green_reg <= ch_res[1];
            blue_reg  <= ch_res[2];
            alpha_reg <= s3_alpha_reg;
            last_reg  <= s3_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = red_reg;
    assign green_out  = green_reg;
    assign blue_out   = blue_reg;
    assign alpha_out  = alpha_reg;
    assign frame_last = last_reg;

endmodule
